// ===== hw/rtl/bitmap_font_text_renderer_macros.svh =====
// Assertion macros shared by the renderer's checker.
`ifndef BITMAP_FONT_TEXT_RENDERER_MACROS_SVH
`define BITMAP_FONT_TEXT_RENDERER_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define BFTR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bftr check failed");

// Next-cycle implication, off while reset is high.
`define BFTR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bftr check failed");

// State right after a reset cycle.
`define BFTR_ASSERT_AFTER_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("bftr reset check failed");

`endif

// ===== hw/rtl/bftr_pkg.sv =====
// Types, constants and codes shared by the text renderer modules.
`default_nettype none

package bftr_pkg;

   // Default sizes
   localparam int GLYPH_COUNT_DEFAULT = 512;
   localparam int SLOT_ROWS_DEFAULT   = 16;
   localparam int CODE_COUNT_DEFAULT  = 256;

   // Request actions
   localparam logic [1:0] ACT_MAP_LOAD   = 2'd0;
   localparam logic [1:0] ACT_GLYPH_LOAD = 2'd1;
   localparam logic [1:0] ACT_WRITE_CHAR = 2'd2;

   // Control characters
   localparam logic [7:0] CODE_NEWLINE = 8'd10;
   localparam logic [7:0] CODE_TAB     = 8'd9;

   // Cursor geometry
   localparam int TAB_STEP   = 36;
   localparam int CELL_STEP  = 9;
   localparam int MAX_ROWS   = 16;

   // x/36 = (x>>2)/9; (x>>2)/9 = ((x>>2) * TAB_RECIP) >> TAB_SHIFT for 14-bit x>>2
   localparam int TAB_RECIP  = 116509;
   localparam int TAB_SHIFT  = 20;

   localparam logic [4:0] FONT_HEIGHT_RESET = 5'd16;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] code;
      logic [8:0] glyph_index;
      logic [3:0] glyph_row;
      logic [7:0] row_data;
   } req_type;

   typedef struct packed {
      logic [15:0] pixel_x;
      logic [15:0] pixel_y;
      logic [7:0]  row_bits;
      logic        last_row;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic map_write;
      logic glyph_write;
      logic map_read;
      logic newline;
      logic tab_mult;
      logic tab_update;
      logic base_load;
      logic row_clr;
      logic row_inc;
      logic rd_en;
      logic out_load;
      logic x_advance;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [1:0] action;
      logic       is_newline;
      logic       is_tab;
      logic       rows_zero;
      logic       row_last;
      logic       out_free;
   } status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/bftr_ctrl.sv =====
// Sequencing state machine for the text renderer.
`default_nettype none

module bftr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  bftr_pkg::status_type   status,
   output bftr_pkg::cmd_type      cmd
);
   import bftr_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DISPATCH = 3'd1;
   localparam logic [2:0] ST_TAB      = 3'd2;
   localparam logic [2:0] ST_MAP      = 3'd3;
   localparam logic [2:0] ST_FETCH    = 3'd4;
   localparam logic [2:0] ST_SEND     = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            state_in = ST_IDLE;
            case (status.action)
               ACT_MAP_LOAD: begin
                  cmd.map_write = 1'b1;
               end
               ACT_GLYPH_LOAD: begin
                  cmd.glyph_write = 1'b1;
               end
               ACT_WRITE_CHAR: begin
                  if (status.is_newline) begin
                     cmd.newline = 1'b1;
                  end else if (status.is_tab) begin
                     cmd.tab_mult = 1'b1;
                     state_in     = ST_TAB;
                  end else begin
                     cmd.map_read = 1'b1;
                     state_in     = ST_MAP;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_TAB: begin
            cmd.tab_update = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_MAP: begin
            cmd.base_load = 1'b1;
            cmd.row_clr   = 1'b1;
            if (status.rows_zero) begin
               cmd.x_advance = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_SEND;
         end
         ST_SEND: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (status.row_last) begin
                  cmd.x_advance = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  cmd.rd_en   = 1'b1;
                  cmd.row_inc = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/bftr_datapath.sv =====
// Cursor, character map, glyph store and result register of the text renderer.
`default_nettype none

module bftr_datapath #(
   parameter int GLYPH_COUNT = bftr_pkg::GLYPH_COUNT_DEFAULT,
   parameter int SLOT_ROWS   = bftr_pkg::SLOT_ROWS_DEFAULT,
   parameter int CODE_COUNT  = bftr_pkg::CODE_COUNT_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bftr_pkg::req_type    req_data,
   input  bftr_pkg::cmd_type    cmd,
   output bftr_pkg::status_type status,
   input  logic                 csr_wr_en,
   input  logic [4:0]           csr_wr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bftr_pkg::rsp_type    rsp_data
);
   import bftr_pkg::*;

   localparam int GLYPH_W     = $clog2(GLYPH_COUNT);
   localparam int MAP_AW      = $clog2(CODE_COUNT);
   localparam int STORE_DEPTH = GLYPH_COUNT * SLOT_ROWS;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int MAX_DRAW    = (SLOT_ROWS < MAX_ROWS) ? SLOT_ROWS : MAX_ROWS;

   localparam logic [8:0] CODE_LIMIT  = 9'(CODE_COUNT);
   localparam logic [9:0] GLYPH_LIMIT = 10'(GLYPH_COUNT);
   localparam logic [5:0] ROW_LIMIT   = 6'(SLOT_ROWS);
   localparam logic [4:0] DRAW_LIMIT  = 5'(MAX_DRAW);

   // request and configuration
   req_type              req_ff;
   logic [4:0]           font_height_ff;

   // cursor
   logic [15:0]          x_ff;
   logic [15:0]          y_ff;

   // character map
   logic [GLYPH_W-1:0]   map_mem [CODE_COUNT];
   logic [CODE_COUNT-1:0] map_vld_ff;
   logic [GLYPH_W-1:0]   map_rd_ff;
   logic                 map_rd_vld_ff;

   // glyph store
   logic [7:0]           store_mem [STORE_DEPTH];
   logic [7:0]           store_rd_ff;
   logic [STORE_AW-1:0]  base_ff;
   logic [3:0]           row_ff;

   // tab divide
   logic [30:0]          prod_ff;

   // result register
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic                 code_ok;
   logic                 map_ok;
   logic                 load_ok;
   logic [MAP_AW-1:0]    map_idx;
   logic [GLYPH_W-1:0]   glyph_sel;
   logic [STORE_AW-1:0]  store_wr_addr;
   logic [STORE_AW-1:0]  base_in;
   logic [3:0]           rd_row;
   logic [STORE_AW-1:0]  rd_addr;
   logic [4:0]           rows;
   logic [30:0]          prod_in;
   logic [10:0]          quot;
   logic [14:0]          quot_rem;
   logic [10:0]          quot_fix;
   logic [15:0]          tab_x;

   assign code_ok = {1'b0, req_ff.code} < CODE_LIMIT;
   assign map_ok  = code_ok && ({1'b0, req_ff.glyph_index} < GLYPH_LIMIT);
   assign load_ok = ({1'b0, req_ff.glyph_index} < GLYPH_LIMIT)
                    && ({2'b00, req_ff.glyph_row} < ROW_LIMIT);
   assign map_idx = req_ff.code[MAP_AW-1:0];

   // codes past the map and never-loaded entries draw glyph 0
   assign glyph_sel = (code_ok && map_rd_vld_ff) ? map_rd_ff : '0;

   assign store_wr_addr = STORE_AW'(req_ff.glyph_index[GLYPH_W-1:0]) * STORE_AW'(SLOT_ROWS)
                          + STORE_AW'(req_ff.glyph_row);
   assign base_in       = STORE_AW'(glyph_sel) * STORE_AW'(SLOT_ROWS);
   assign rd_row        = cmd.row_inc ? (row_ff + 4'd1) : row_ff;
   assign rd_addr       = base_ff + STORE_AW'(rd_row);

   assign rows = (font_height_ff > DRAW_LIMIT) ? DRAW_LIMIT : font_height_ff;

   // next multiple of 36 = 36 * (x/36 + 1), with x/36 = (x>>2)/9
   assign prod_in  = 31'(x_ff[15:2]) * 31'(TAB_RECIP);
   assign quot     = prod_ff[TAB_SHIFT +: 11];
   assign quot_rem = 15'(x_ff[15:2]) - 15'(quot) * 15'(CELL_STEP);
   assign quot_fix = (quot_rem >= 15'(CELL_STEP)) ? (quot + 11'd1) : quot;
   assign tab_x    = 16'(17'(quot_fix) * 17'(TAB_STEP) + 17'(TAB_STEP));

   assign status.action     = req_ff.action;
   assign status.is_newline = (req_ff.code == CODE_NEWLINE);
   assign status.is_tab     = (req_ff.code == CODE_TAB);
   assign status.rows_zero  = (rows == 5'd0);
   assign status.row_last   = (({1'b0, row_ff} + 5'd1) == rows);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         font_height_ff <= FONT_HEIGHT_RESET;
      end else if (csr_wr_en) begin
         font_height_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         y_ff <= '0;
      end else if (cmd.newline) begin
         x_ff <= '0;
         y_ff <= y_ff + 16'(font_height_ff) + 16'd1;
      end else if (cmd.tab_update) begin
         x_ff <= tab_x;
      end else if (cmd.x_advance) begin
         x_ff <= x_ff + 16'(CELL_STEP);
      end
   end

   // map valid bits: cleared at reset, stand in for an all-zero map
   always_ff @(posedge clock) begin
      if (reset) begin
         map_vld_ff <= '0;
      end else if (cmd.map_write && map_ok) begin
         map_vld_ff[map_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.map_write && map_ok) begin
         map_mem[map_idx] <= req_ff.glyph_index[GLYPH_W-1:0];
      end
      if (cmd.map_read) begin
         map_rd_ff     <= map_mem[map_idx];
         map_rd_vld_ff <= map_vld_ff[map_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.glyph_write && load_ok) begin
         store_mem[store_wr_addr] <= req_ff.row_data;
      end
      if (cmd.rd_en) begin
         store_rd_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.base_load) begin
         base_ff <= base_in;
      end
      if (cmd.row_clr) begin
         row_ff <= '0;
      end else if (cmd.row_inc) begin
         row_ff <= row_ff + 4'd1;
      end
      if (cmd.tab_mult) begin
         prod_ff <= prod_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.pixel_x  <= x_ff;
         rsp_ff.pixel_y  <= y_ff + 16'(row_ff);
         rsp_ff.row_bits <= store_rd_ff;
         rsp_ff.last_row <= status.row_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_font_text_renderer.sv =====
// Bitmap font text renderer: top level joining the controller and the datapath.
//
// Character-cell text renderer. A request either loads a character map entry
// (code -> glyph number), loads one glyph row byte into the glyph store, or
// writes a character at the pixel cursor. Newline sets x to 0 and moves y down
// by font_height+1; tab moves x to the next multiple of 36; any other code
// draws min(font_height, SLOT_ROWS, 16) rows, one response per row carrying x,
// y+row, the row pattern (MSB leftmost) and a last-row flag, then moves x by 9
// on the same line. Cursor math wraps at 16 bits. The map reads as glyph 0
// until loaded (per-entry valid bits, no clearing pass). Glyph store bytes
// never loaded read back as garbage. A map or glyph load or a newline is
// captured, then applied; a tab also registers the reciprocal multiply of the
// divide by 36 before x moves. A drawn character goes through capture, decode,
// map lookup and the first store read, then sends one row per cycle while the
// response is not stalled, through the single read port of the glyph store;
// with font_height 0 nothing is drawn.
// csr_wr_en writes font_height; write it only while no request is in flight.
`default_nettype none

module bitmap_font_text_renderer #(
   parameter int GLYPH_COUNT = bftr_pkg::GLYPH_COUNT_DEFAULT,
   parameter int SLOT_ROWS   = bftr_pkg::SLOT_ROWS_DEFAULT,
   parameter int CODE_COUNT  = bftr_pkg::CODE_COUNT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  bftr_pkg::req_type req_data,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bftr_pkg::rsp_type rsp_data,
   // font_height register
   input  logic              csr_wr_en,
   input  logic [4:0]        csr_wr_data
);
   import bftr_pkg::*;

   cmd_type    cmd;      // per-cycle strobes from the sequencer
   status_type status;   // decode and row-count flags back to it

   bftr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bftr_datapath #(
      .GLYPH_COUNT (GLYPH_COUNT),
      .SLOT_ROWS   (SLOT_ROWS),
      .CODE_COUNT  (CODE_COUNT)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .cmd         (cmd),
      .status      (status),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/bftr_checker.sv =====
// Port-level checker for the text renderer, bound to the top level.
`default_nettype none

`include "bitmap_font_text_renderer_macros.svh"

module bftr_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input bftr_pkg::rsp_type rsp_data
);

   // a stalled response holds
   `BFTR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // while a non-final row is out, the rest of the glyph is still pending
   `BFTR_ASSERT_NOW(a_busy_mid_glyph, clock, reset, rsp_valid && !rsp_data.last_row, req_stall)

   // every accepted request leaves the block busy with it
   `BFTR_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // reset leaves the block idle with nothing to send
   `BFTR_ASSERT_AFTER_RESET(a_reset_idle, clock, reset, !rsp_valid && !req_stall)

endmodule

bind bitmap_font_text_renderer bftr_checker u_checker (.*);

`default_nettype wire
